// ----- hw/rtl/energy_buffer_current_limiter_defines.svh -----
// ----------------------------------------------------------------------------
// Energy buffer current limiter: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ENERGY_BUFFER_CURRENT_LIMITER_DEFINES_SVH
`define ENERGY_BUFFER_CURRENT_LIMITER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define EBCL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define EBCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ebcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Energy buffer current limiter package
// Field widths, register map, reset values and the payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebcl_pkg;

	localparam int NUM_WHEELS = 4;
	localparam int CURRENT_W  = 16;
	localparam int ENERGY_W   = 16;
	localparam int LIMIT_W    = 18;
	localparam int MAG_W      = CURRENT_W + 1;       // magnitude of -32768 needs 17 bits
	localparam int TOTAL_W    = 18;                  // four magnitudes sum to at most 131072
	localparam int ESQ_W      = 2 * ENERGY_W;        // energy squared
	localparam int NUM_W      = ESQ_W + LIMIT_W;     // energy^2 * current threshold
	localparam int LQ_W       = LIMIT_W;             // quotient bits of the limit division
	localparam int SQ_W       = CURRENT_W - 1;       // scaled magnitude is below the input one
	localparam int PROD_W     = MAG_W + LIMIT_W;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_BUF_THRESH              = 1'b0;
	localparam logic REG_TOTAL_CURRENT_THRESHOLD = 1'b1;

	localparam logic [ENERGY_W-1:0] BUF_THRESH_RST              = 16'd10240;
	localparam logic [LIMIT_W-1:0]  TOTAL_CURRENT_THRESHOLD_RST = 18'd40000;
	localparam logic [ESQ_W-1:0]    THRESHOLD_SQ_RST =
		ESQ_W'(BUF_THRESH_RST) * ESQ_W'(BUF_THRESH_RST);

	typedef struct packed {
		logic signed [CURRENT_W-1:0] current_fr;
		logic signed [CURRENT_W-1:0] current_fl;
		logic signed [CURRENT_W-1:0] current_bl;
		logic signed [CURRENT_W-1:0] current_br;
		logic        [ENERGY_W-1:0]  buf_energy;
	} cmd_t;

	typedef struct packed {
		logic signed [CURRENT_W-1:0] limited_fr;
		logic signed [CURRENT_W-1:0] limited_fl;
		logic signed [CURRENT_W-1:0] limited_bl;
		logic signed [CURRENT_W-1:0] limited_br;
		logic                        was_limited;
		logic        [LIMIT_W-1:0]   current_limit;
	} res_t;

endpackage

// ----- hw/rtl/energy_buffer_current_limiter.sv -----
// ----------------------------------------------------------------------------
// Energy buffer current limiter
// Scales four wheel current commands so that their absolute sum stays within
// a limit derived from the remaining power-buffer energy.
// ----------------------------------------------------------------------------
// The block takes one command transfer per clock while cmd_ready is high and
// returns one result per command, in order. The pipeline is built from
// two restoring dividers laid out one quotient bit per stage: 18 stages
// for the energy-based limit (energy^2 * threshold / threshold_energy^2) and
// 15 stages for the per-wheel scaling (current * limit / total), with the four
// wheels running in parallel lanes. Results sit in a two-entry output buffer,
// so the pipeline keeps taking commands while one result waits; only
// when both entries are held does cmd_ready drop. Registers: the energy
// threshold at byte address 0, total_current_threshold at 4; write them only
// while no command is in flight.
`timescale 1ns / 1ps

module energy_buffer_current_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  ebcl_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ebcl_pkg::res_t                res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ebcl_pkg::ADDR_W-1:0]   paddr,
	input  logic [ebcl_pkg::DATA_W-1:0]   pwdata,
	output logic [ebcl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int NW      = ebcl_pkg::NUM_WHEELS;
	localparam int CUR_W   = ebcl_pkg::CURRENT_W;
	localparam int EN_W    = ebcl_pkg::ENERGY_W;
	localparam int LIM_W   = ebcl_pkg::LIMIT_W;
	localparam int MAG_W   = ebcl_pkg::MAG_W;
	localparam int TOT_W   = ebcl_pkg::TOTAL_W;
	localparam int ESQ_W   = ebcl_pkg::ESQ_W;
	localparam int NUM_W   = ebcl_pkg::NUM_W;
	localparam int LQ      = ebcl_pkg::LQ_W;
	localparam int SQ      = ebcl_pkg::SQ_W;
	localparam int PROD_W  = ebcl_pkg::PROD_W;

	typedef logic [NW-1:0][CUR_W-1:0] cur_vec_t;
	typedef logic [NW-1:0][MAG_W-1:0] mag_vec_t;

	typedef struct packed {
		cur_vec_t          raw;
		mag_vec_t          mag;
		logic [TOT_W-1:0]  total;
		logic              over;
	} lim_side_t;

	typedef struct packed {
		cur_vec_t          raw;
		logic [LIM_W-1:0]  limit;
		logic [TOT_W-1:0]  total;
		logic              limited;
	} scl_side_t;

	// ---------------------------------------------------------------- config
	logic [EN_W-1:0]  eth_q;
	logic [LIM_W-1:0] tct_q;
	logic [ESQ_W-1:0] thsq_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eth_q  <= ebcl_pkg::BUF_THRESH_RST;
			tct_q  <= ebcl_pkg::TOTAL_CURRENT_THRESHOLD_RST;
			thsq_q <= ebcl_pkg::THRESHOLD_SQ_RST;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[ebcl_pkg::ADDR_W-1])
					ebcl_pkg::REG_BUF_THRESH:              eth_q <= pwdata[EN_W-1:0];
					ebcl_pkg::REG_TOTAL_CURRENT_THRESHOLD: tct_q <= pwdata[LIM_W-1:0];
				endcase
			end
			// divisor follows the threshold in the next cycle, long before it is used
			thsq_q <= ESQ_W'(eth_q) * ESQ_W'(eth_q);
		end
	end

	always_comb begin
		unique case (paddr[ebcl_pkg::ADDR_W-1])
			ebcl_pkg::REG_BUF_THRESH:              prdata = ebcl_pkg::DATA_W'(eth_q);
			ebcl_pkg::REG_TOTAL_CURRENT_THRESHOLD: prdata = ebcl_pkg::DATA_W'(tct_q);
		endcase
	end

	// ----------------------------------------------------------- flow control
	logic       en;
	logic [1:0] cnt_q;
	logic       full;

	assign full      = (cnt_q == 2'd2);
	assign en        = ~full;
	assign cmd_ready = en;

	// ------------------------------------------------ stage 1: magnitudes, e^2
	cur_vec_t         cur_d;
	mag_vec_t         mag_d;
	logic             v_s1;
	cur_vec_t         raw_s1;
	mag_vec_t         mag_s1;
	logic [EN_W-1:0]  energy_s1;
	logic [ESQ_W-1:0] esq_s1;

	always_comb begin
		cur_d[0] = cmd.current_fr;
		cur_d[1] = cmd.current_fl;
		cur_d[2] = cmd.current_bl;
		cur_d[3] = cmd.current_br;
		for (int i = 0; i < NW; i++) begin
			mag_d[i] = cur_d[i][CUR_W-1] ? (~{1'b1, cur_d[i]} + MAG_W'(1))
			                             : {1'b0, cur_d[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1    <= cur_d;
			mag_s1    <= mag_d;
			energy_s1 <= cmd.buf_energy;
			esq_s1    <= ESQ_W'(cmd.buf_energy) * ESQ_W'(cmd.buf_energy);
		end
	end

	// --------------------------------- limit divider, index 0 is stage 2 load
	logic [LQ:0]        ld_v_s;
	logic [ESQ_W-1:0]   ld_rem_s  [LQ+1];
	logic [LQ-1:0]      ld_low_s  [LQ+1];
	logic [LQ-1:0]      ld_quo_s  [LQ+1];
	lim_side_t          ld_side_s [LQ+1];
	logic [NUM_W-1:0]   num_d;
	logic [TOT_W-1:0]   total_d;

	always_comb begin
		num_d   = NUM_W'(esq_s1) * NUM_W'(tct_q);
		total_d = '0;
		for (int i = 0; i < NW; i++) begin
			total_d = total_d + TOT_W'(mag_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// numerator < divisor * 2^LQ whenever the quotient is used
			ld_rem_s[0]        <= num_d[NUM_W-1:LQ];
			ld_low_s[0]        <= num_d[LQ-1:0];
			ld_quo_s[0]        <= '0;
			ld_side_s[0].raw   <= raw_s1;
			ld_side_s[0].mag   <= mag_s1;
			ld_side_s[0].total <= total_d;
			ld_side_s[0].over  <= (energy_s1 > eth_q);
		end
	end

	for (genvar k = 1; k <= LQ; k++) begin : g_ldiv
		logic [ESQ_W:0] trial;
		logic           fits;

		always_comb begin
			trial = {ld_rem_s[k-1], ld_low_s[k-1][LQ-1]};
			fits  = (trial >= {1'b0, thsq_q});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ld_rem_s[k]  <= fits ? ESQ_W'(trial - {1'b0, thsq_q}) : trial[ESQ_W-1:0];
				ld_low_s[k]  <= {ld_low_s[k-1][LQ-2:0], 1'b0};
				ld_quo_s[k]  <= {ld_quo_s[k-1][LQ-2:0], fits};
				ld_side_s[k] <= ld_side_s[k-1];
			end
		end
	end

	// ------------------------------------------------- limit select, compare
	logic              sel_v_s;
	logic [LIM_W-1:0]  sel_limit_d;
	logic [LIM_W-1:0]  sel_limit_s;
	logic              sel_limited_s;
	cur_vec_t          sel_raw_s;
	mag_vec_t          sel_mag_s;
	logic [TOT_W-1:0]  sel_total_s;

	always_comb begin
		if (ld_side_s[LQ].over) begin
			sel_limit_d = tct_q;
		end else if (eth_q == '0) begin
			sel_limit_d = '0;
		end else begin
			sel_limit_d = ld_quo_s[LQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_limit_s   <= sel_limit_d;
			sel_limited_s <= (ld_side_s[LQ].total > sel_limit_d);
			sel_raw_s     <= ld_side_s[LQ].raw;
			sel_mag_s     <= ld_side_s[LQ].mag;
			sel_total_s   <= ld_side_s[LQ].total;
		end
	end

	// ------------------ scaling divider, index 0 is the product stage load
	logic [SQ:0]                  sd_v_s;
	logic [NW-1:0][TOT_W-1:0]     sd_rem_s  [SQ+1];
	logic [NW-1:0][SQ-1:0]        sd_low_s  [SQ+1];
	logic [NW-1:0][SQ-1:0]        sd_quo_s  [SQ+1];
	scl_side_t                    sd_side_s [SQ+1];
	logic [NW-1:0][PROD_W-1:0]    prod_d;

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			prod_d[i] = PROD_W'(sel_mag_s[i]) * PROD_W'(sel_limit_s);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				// when scaling applies, product < total * 2^SQ
				sd_rem_s[0][i] <= prod_d[i][SQ+TOT_W-1:SQ];
				sd_low_s[0][i] <= prod_d[i][SQ-1:0];
			end
			sd_quo_s[0]          <= '0;
			sd_side_s[0].raw     <= sel_raw_s;
			sd_side_s[0].limit   <= sel_limit_s;
			sd_side_s[0].total   <= sel_total_s;
			sd_side_s[0].limited <= sel_limited_s;
		end
	end

	for (genvar k = 1; k <= SQ; k++) begin : g_sdiv
		logic [NW-1:0][TOT_W:0]   trial;
		logic [NW-1:0]            fits;
		logic [NW-1:0][TOT_W-1:0] nrem;

		always_comb begin
			for (int i = 0; i < NW; i++) begin
				trial[i] = {sd_rem_s[k-1][i], sd_low_s[k-1][i][SQ-1]};
				fits[i]  = (trial[i] >= {1'b0, sd_side_s[k-1].total});
				nrem[i]  = fits[i] ? TOT_W'(trial[i] - {1'b0, sd_side_s[k-1].total})
				                   : trial[i][TOT_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < NW; i++) begin
					sd_rem_s[k][i] <= nrem[i];
					sd_low_s[k][i] <= {sd_low_s[k-1][i][SQ-2:0], 1'b0};
					sd_quo_s[k][i] <= {sd_quo_s[k-1][i][SQ-2:0], fits[i]};
				end
				sd_side_s[k] <= sd_side_s[k-1];
			end
		end
	end

	// -------------------------------------------------- valid bits, all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			ld_v_s  <= '0;
			sel_v_s <= 1'b0;
			sd_v_s  <= '0;
		end else if (en) begin
			v_s1    <= cmd_valid;
			ld_v_s  <= {ld_v_s[LQ-1:0], v_s1};
			sel_v_s <= ld_v_s[LQ];
			sd_v_s  <= {sd_v_s[SQ-1:0], sel_v_s};
		end
	end

	// ------------------------------------------------- sign restore, result
	logic [NW-1:0][CUR_W-1:0] scaled_d;
	logic [NW-1:0][CUR_W-1:0] out_d;
	ebcl_pkg::res_t           res_d;

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			scaled_d[i] = {1'b0, sd_quo_s[SQ][i]};
			if (!sd_side_s[SQ].limited) begin
				out_d[i] = sd_side_s[SQ].raw[i];
			end else if (sd_side_s[SQ].raw[i][CUR_W-1]) begin
				out_d[i] = ~scaled_d[i] + CUR_W'(1);
			end else begin
				out_d[i] = scaled_d[i];
			end
		end
		res_d.limited_fr    = out_d[0];
		res_d.limited_fl    = out_d[1];
		res_d.limited_bl    = out_d[2];
		res_d.limited_br    = out_d[3];
		res_d.was_limited   = sd_side_s[SQ].limited;
		res_d.current_limit = sd_side_s[SQ].limit;
	end

	// ------------------------------------------- two-entry output buffer
	ebcl_pkg::res_t obuf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic           push;
	logic           pop;

	assign push      = sd_v_s[SQ] & en;
	assign pop       = res_valid & res_ready;
	assign res_valid = (cnt_q != 2'd0);
	assign res       = obuf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[wr_ptr_q] <= res_d;
		end
	end

endmodule

// ----- hw/rtl/ebcl_checker.sv -----
// ----------------------------------------------------------------------------
// Energy buffer current limiter checker
// Port-level assertions on the limiter, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "energy_buffer_current_limiter_defines.svh"

module ebcl_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_ready,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  ebcl_pkg::res_t                res
);

	localparam int TOT_W = ebcl_pkg::TOTAL_W;
	localparam int CUR_W = ebcl_pkg::CURRENT_W;

	function automatic logic [TOT_W-1:0] mag_of(input logic [CUR_W-1:0] v);
		return v[CUR_W-1] ? ({{(TOT_W-CUR_W){1'b0}}, ~v} + TOT_W'(1))
		                  : {{(TOT_W-CUR_W){1'b0}}, v};
	endfunction

	logic [TOT_W-1:0] mag_sum;

	// truncated scaled magnitudes never add up to more than the limit
	assign mag_sum = mag_of(res.limited_fr) + mag_of(res.limited_fl)
	               + mag_of(res.limited_bl) + mag_of(res.limited_br);

	`EBCL_ASSERT_IMPL(a_stall_has_result, clk, arst_n, !cmd_ready, res_valid, "command stalled with no result waiting")
	`EBCL_ASSERT_IMPL(a_scaled_within_limit, clk, arst_n, res_valid && res.was_limited, mag_sum <= res.current_limit, "scaled currents exceed the limit")
	`EBCL_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "result changed before its transfer")

endmodule

bind energy_buffer_current_limiter ebcl_checker u_ebcl_checker (.*);
